/* sv/bgl_pkg.sv */
`timescale 1ns / 1ps
// bgl_pkg: operation codes, sequencer states and constants for the
// bidirectional galois lfsr; no dependencies

package bgl_pkg;

    localparam int OP_W       = 3;
    localparam int SEEK_W     = 17;
    localparam int LOAD_W     = 32;
    localparam int DATA_W     = 8;
    localparam int STATE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int COLL_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_NEXT_BIT  = 3'd0,
        OP_NEXT_BYTE = 3'd1,
        OP_PREV_BIT  = 3'd2,
        OP_PREV_BYTE = 3'd3,
        OP_SEEK      = 3'd4,
        OP_SYNC      = 3'd5,
        OP_RELOAD    = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PRE,
        ST_MIRROR,
        ST_SHIFT,
        ST_COLLECT,
        ST_LOAD,
        ST_SYNC,
        ST_DONE
    } state_t;

    // what follows the shift phase
    typedef enum logic [2:0] {
        KIND_INIT,
        KIND_BITS,
        KIND_SYNC,
        KIND_RELOAD,
        KIND_NONE
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_STATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_REVERSED = 2'd2;

    localparam logic [31:0] POLY_RESET = 32'd184;
    localparam logic [31:0] SEED_RESET = 32'd1;
    localparam logic        REV_RESET  = 1'b0;

    localparam logic [SEEK_W-1:0] SHIFT_ONE    = 17'd1;
    localparam logic [SEEK_W-1:0] SHIFT_RESYNC = 17'd9;
    localparam logic [COLL_W-1:0] COLL_BIT     = 4'd1;
    localparam logic [COLL_W-1:0] COLL_BYTE    = 4'd8;

endpackage

/* sv/bidirectional_galois_lfsr.sv */
`timescale 1ns / 1ps
// bidirectional_galois_lfsr: galois lfsr run bit-serially by a small sequencer,
// forward or backward through an in-place mirror of polynomial and state
// depends on bgl_pkg
//
// usage
// - input channel (in_valid/in_ready) takes one beat: operation, seek_offset,
//   load_value; output channel (out_valid/out_ready) returns one beat per
//   input beat: data_out and state_out after the step
// - cfg_wr_en/cfg_index/cfg_data write polynomial (0), seed_state (1) and
//   start_reversed (2); any of them re-initializes the register through the
//   init state, followed by the start mirror when start_reversed is set
// - one lfsr step per cycle: a bit op collects one bit, a byte op eight;
//   leaving the mirrored sense costs a mirror plus up to 10 resync steps;
//   a seek runs |seek_offset| steps plus a mirror when the direction flips;
//   sync shifts load_value in over the register length, reload loads it,
//   each after a mirror when the register runs mirrored
// - in_ready is high only while idle, so a new beat is taken the cycle after
//   the result is registered; a result held by a stalled receiver lets the
//   next beat in and blocks only at that beat's completion
// - reset loads polynomial 184, seed 1, forward sense, then goes through the
//   init cycle before in_ready rises

module bidirectional_galois_lfsr
    import bgl_pkg::*;
#(
    parameter int MAX_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [OP_W-1:0]         operation,
    input  logic signed [SEEK_W-1:0] seek_offset,
    input  logic [LOAD_W-1:0]       load_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DATA_W-1:0]       data_out,
    output logic [STATE_W-1:0]      state_out,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int REG_W = (MAX_BITS < 32) ? MAX_BITS : 32;

    state_t                state_reg, state_next;
    logic [31:0]           poly_cfg_reg, poly_cfg_next;
    logic [31:0]           seed_cfg_reg, seed_cfg_next;
    logic                  rev_cfg_reg, rev_cfg_next;
    logic [REG_W-1:0]      s_reg, s_next;
    logic [REG_W-1:0]      p_reg, p_next;
    logic [REG_W-1:0]      mask_reg, mask_next;
    logic [REG_W-1:0]      top_reg, top_next;
    logic [REG_W-1:0]      marker_reg, marker_next;
    logic [REG_W-1:0]      acc_s_reg, acc_s_next;
    logic [REG_W-1:0]      acc_p_reg, acc_p_next;
    logic [REG_W-1:0]      load_reg, load_next;
    logic [SEEK_W-1:0]     cnt_reg, cnt_next;
    logic [COLL_W-1:0]     coll_reg, coll_next;
    logic                  mir_reg, mir_next;
    logic                  byte_reg, byte_next;
    logic                  prev_reg, prev_next;
    kind_t                 kind_reg, kind_next;
    logic [DATA_W-1:0]     data_reg, data_next;
    logic                  mflag_reg, mflag_next;
    logic                  bm_reg, bm_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     data_out_reg, data_out_next;
    logic [STATE_W-1:0]    state_out_reg, state_out_next;

    logic [REG_W-1:0]      init_mask;
    logic [REG_W-1:0]      init_top;
    logic [REG_W-1:0]      step_s;
    logic [REG_W-1:0]      sync_pre;
    logic                  sync_bit;
    logic                  accept;
    logic                  cfg_hit;
    logic                  finish;
    logic [SEEK_W-1:0]     seek_raw;
    logic [SEEK_W-1:0]     seek_mag;
    logic                  seek_neg;
    logic                  plan_pre;
    logic                  plan_mir;
    logic [SEEK_W-1:0]     plan_cnt;
    logic [COLL_W-1:0]     plan_coll;
    logic                  plan_byte;
    logic                  plan_prev;
    kind_t                 plan_kind;
    logic                  plan_bm;
    state_t                plan_first;

    function automatic state_t tail_state(input kind_t kind);
        state_t st;
        unique case (kind)
            KIND_INIT:   st = ST_IDLE;
            KIND_BITS:   st = ST_COLLECT;
            KIND_SYNC:   st = ST_LOAD;
            KIND_RELOAD: st = ST_LOAD;
            default:     st = ST_DONE;
        endcase
        return st;
    endfunction

    // register length mask and top bit from the polynomial
    always_comb
    begin
        init_mask = poly_cfg_reg[REG_W-1:0];
        for (int k = 1; k < REG_W; k = k * 2)
        begin
            init_mask = init_mask | (init_mask >> k);
        end
        init_top = init_mask ^ (init_mask >> 1);
    end

    assign step_s   = (s_reg >> 1) ^ (s_reg[0] ? p_reg : '0);
    assign sync_bit = |(load_reg & marker_reg);
    assign sync_pre = sync_bit ? (s_reg ^ p_reg) : s_reg;
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign finish   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign cfg_hit  = cfg_wr_en && ((cfg_index == CFG_POLYNOMIAL) ||
                      (cfg_index == CFG_SEED_STATE) || (cfg_index == CFG_START_REVERSED));
    assign seek_raw = seek_offset;
    assign seek_neg = seek_raw[SEEK_W-1];
    assign seek_mag = seek_neg ? SEEK_W'({SEEK_W{1'b0}} - seek_raw) : seek_raw;

    // per-beat plan: resync shifts, mirror, shift count, bits to collect
    always_comb
    begin
        plan_pre  = 1'b0;
        plan_mir  = 1'b0;
        plan_cnt  = '0;
        plan_coll = '0;
        plan_byte = 1'b0;
        plan_prev = 1'b0;
        plan_kind = KIND_NONE;
        plan_bm   = bm_reg;
        unique case (op_t'(operation))
            OP_NEXT_BIT:
            begin
                plan_mir  = mflag_reg;
                plan_cnt  = mflag_reg ? SHIFT_ONE : '0;
                plan_coll = COLL_BIT;
                plan_kind = KIND_BITS;
                plan_bm   = 1'b0;
            end
            OP_PREV_BIT:
            begin
                plan_mir  = !mflag_reg;
                plan_cnt  = !mflag_reg ? SHIFT_ONE : '0;
                plan_coll = COLL_BIT;
                plan_prev = 1'b1;
                plan_kind = KIND_BITS;
                plan_bm   = 1'b0;
            end
            OP_NEXT_BYTE:
            begin
                plan_pre  = mflag_reg;
                plan_mir  = mflag_reg;
                plan_cnt  = !mflag_reg ? '0 : (bm_reg ? SHIFT_RESYNC : SHIFT_ONE);
                plan_coll = COLL_BYTE;
                plan_byte = 1'b1;
                plan_kind = KIND_BITS;
                plan_bm   = 1'b1;
            end
            OP_PREV_BYTE:
            begin
                plan_pre  = !mflag_reg;
                plan_mir  = !mflag_reg;
                plan_cnt  = mflag_reg ? '0 : (bm_reg ? SHIFT_RESYNC : SHIFT_ONE);
                plan_coll = COLL_BYTE;
                plan_byte = 1'b1;
                plan_prev = 1'b1;
                plan_kind = KIND_BITS;
                plan_bm   = 1'b1;
            end
            OP_SEEK:
            begin
                plan_mir  = seek_neg ^ mflag_reg;
                plan_cnt  = seek_mag;
                plan_bm   = 1'b0;
            end
            OP_SYNC:
            begin
                plan_mir  = mflag_reg;
                plan_kind = KIND_SYNC;
                plan_bm   = 1'b0;
            end
            OP_RELOAD:
            begin
                plan_mir  = mflag_reg;
                plan_kind = KIND_RELOAD;
                plan_bm   = 1'b0;
            end
            default:
            begin
                plan_kind = KIND_NONE;
            end
        endcase
        if (plan_pre)
        begin
            plan_first = ST_PRE;
        end
        else if (plan_mir)
        begin
            plan_first = ST_MIRROR;
        end
        else if (plan_cnt != '0)
        begin
            plan_first = ST_SHIFT;
        end
        else
        begin
            plan_first = tail_state(plan_kind);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                state_next = rev_cfg_reg ? ST_MIRROR : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = plan_first;
                end
            end
            ST_PRE:
            begin
                if (mir_reg)
                begin
                    state_next = ST_MIRROR;
                end
                else
                begin
                    state_next = (cnt_reg != '0) ? ST_SHIFT : tail_state(kind_reg);
                end
            end
            ST_MIRROR:
            begin
                if (marker_reg == '0)
                begin
                    state_next = (cnt_reg != '0) ? ST_SHIFT : tail_state(kind_reg);
                end
            end
            ST_SHIFT:
            begin
                if (cnt_reg == SHIFT_ONE)
                begin
                    state_next = tail_state(kind_reg);
                end
            end
            ST_COLLECT:
            begin
                if (coll_reg == COLL_BIT)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                state_next = (kind_reg == KIND_SYNC) ? ST_SYNC : ST_DONE;
            end
            ST_SYNC:
            begin
                if (marker_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (cfg_hit)
        begin
            state_next = ST_INIT;
        end
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = out_valid_reg;
        data_out  = data_out_reg;
        state_out = state_out_reg;
    end

    // datapath
    always_comb
    begin
        poly_cfg_next  = poly_cfg_reg;
        seed_cfg_next  = seed_cfg_reg;
        rev_cfg_next   = rev_cfg_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        mask_next      = mask_reg;
        top_next       = top_reg;
        marker_next    = marker_reg;
        acc_s_next     = acc_s_reg;
        acc_p_next     = acc_p_reg;
        load_next      = load_reg;
        cnt_next       = cnt_reg;
        coll_next      = coll_reg;
        mir_next       = mir_reg;
        byte_next      = byte_reg;
        prev_next      = prev_reg;
        kind_next      = kind_reg;
        data_next      = data_reg;
        mflag_next     = mflag_reg;
        bm_next        = bm_reg;
        out_valid_next = out_valid_reg;
        data_out_next  = data_out_reg;
        state_out_next = state_out_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                s_next      = seed_cfg_reg[REG_W-1:0] & init_mask;
                p_next      = poly_cfg_reg[REG_W-1:0];
                mask_next   = init_mask;
                top_next    = init_top;
                marker_next = init_mask;
                acc_s_next  = '0;
                acc_p_next  = '0;
                cnt_next    = '0;
                kind_next   = KIND_INIT;
                mflag_next  = 1'b0;
                bm_next     = 1'b0;
            end
            ST_IDLE:
            begin
                marker_next = mask_reg;
                acc_s_next  = '0;
                acc_p_next  = '0;
                if (accept)
                begin
                    mir_next  = plan_mir;
                    cnt_next  = plan_cnt;
                    coll_next = plan_coll;
                    byte_next = plan_byte;
                    prev_next = plan_prev;
                    kind_next = plan_kind;
                    bm_next   = plan_bm;
                    data_next = '0;
                    load_next = load_value[REG_W-1:0];
                end
            end
            ST_PRE:
            begin
                s_next      = step_s;
                marker_next = mask_reg;
                acc_s_next  = '0;
                acc_p_next  = '0;
            end
            ST_MIRROR:
            begin
                if (marker_reg != '0)
                begin
                    acc_s_next  = {acc_s_reg[REG_W-2:0], s_reg[0]};
                    acc_p_next  = {acc_p_reg[REG_W-2:0], p_reg[0]};
                    s_next      = s_reg >> 1;
                    p_next      = p_reg >> 1;
                    marker_next = marker_reg >> 1;
                end
                else
                begin
                    s_next = acc_s_reg;
                    p_next = (acc_p_reg >> 1) | top_reg;
                    if (kind_reg != KIND_INIT)
                    begin
                        mflag_next = !mflag_reg;
                    end
                end
            end
            ST_SHIFT:
            begin
                s_next   = step_s;
                cnt_next = cnt_reg - SHIFT_ONE;
            end
            ST_COLLECT:
            begin
                s_next    = step_s;
                coll_next = coll_reg - COLL_BIT;
                if (byte_reg && prev_reg)
                begin
                    data_next = {s_reg[0], data_reg[DATA_W-1:1]};
                end
                else
                begin
                    data_next = {data_reg[DATA_W-2:0], s_reg[0]};
                end
            end
            ST_LOAD:
            begin
                if (kind_reg == KIND_SYNC)
                begin
                    s_next      = '0;
                    marker_next = top_reg;
                end
                else
                begin
                    s_next = load_reg & mask_reg;
                end
            end
            ST_SYNC:
            begin
                if (marker_reg != '0)
                begin
                    s_next      = ((sync_pre << 1) & mask_reg) | REG_W'(sync_bit);
                    marker_next = marker_reg >> 1;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    data_out_next  = data_reg;
                    state_out_next = STATE_W'(s_reg);
                end
            end
            default:
            begin
                s_next = s_reg;
            end
        endcase

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_POLYNOMIAL:     poly_cfg_next = cfg_data;
                CFG_SEED_STATE:     seed_cfg_next = cfg_data;
                CFG_START_REVERSED: rev_cfg_next  = cfg_data[0];
                default:            rev_cfg_next  = rev_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            poly_cfg_reg  <= POLY_RESET;
            seed_cfg_reg  <= SEED_RESET;
            rev_cfg_reg   <= REV_RESET;
            kind_reg      <= KIND_INIT;
            mflag_reg     <= 1'b0;
            bm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            poly_cfg_reg  <= poly_cfg_next;
            seed_cfg_reg  <= seed_cfg_next;
            rev_cfg_reg   <= rev_cfg_next;
            kind_reg      <= kind_next;
            mflag_reg     <= mflag_next;
            bm_reg        <= bm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        p_reg         <= p_next;
        mask_reg      <= mask_next;
        top_reg       <= top_next;
        marker_reg    <= marker_next;
        acc_s_reg     <= acc_s_next;
        acc_p_reg     <= acc_p_next;
        load_reg      <= load_next;
        cnt_reg       <= cnt_next;
        coll_reg      <= coll_next;
        mir_reg       <= mir_next;
        byte_reg      <= byte_next;
        prev_reg      <= prev_next;
        data_reg      <= data_next;
        data_out_reg  <= data_out_next;
        state_out_reg <= state_out_next;
    end

    // state never holds bits above the register length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((s_reg & ~mask_reg) == '0))
        else $error("lfsr state outside register length");

    // the working polynomial keeps its top tap in either sense
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((p_reg & top_reg) == top_reg))
        else $error("working polynomial lost its top tap");

    // shift phase only runs with steps left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (cnt_reg != '0))
        else $error("shift phase entered with zero count");

    // an accepted beat always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !cfg_wr_en) |=> !in_ready)
        else $error("sequencer stayed idle after accepting a beat");

endmodule
